// ===== hdl/bfds_pkg.sv =====
// ----------------------------------------------------------------------------
// bfds_pkg: shared types and constants of the back-to-front depth sorter
// Field widths, the stored entry format, register codes and the control
// state encoding used by the key unit, the sorter cells and the top level.
// ----------------------------------------------------------------------------
package bfds_pkg;

	localparam int COORD_W     = 24;
	localparam int DIFF_W      = COORD_W + 1;
	localparam int SQ_W        = 2 * COORD_W;
	localparam int KEY_W       = SQ_W + 2;
	localparam int TAG_W       = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int S_TDATA_W   = TAG_W + 6 * COORD_W;
	localparam int S_TUSER_W   = 2;
	localparam int M_TDATA_W   = TAG_W;
	localparam int M_TUSER_W   = 1;
	localparam int MAX_OBJECTS = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAMERA_X = 2'd0,
		REG_CAMERA_Y = 2'd1,
		REG_CAMERA_Z = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_FLUSH,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} entry_t;

	// keyed word leaving the key unit
	typedef struct packed {
		logic             store;
		logic             last;
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} key_word_t;

	typedef struct packed {
		logic insert;
		logic shift_down;
	} cell_ctrl_t;

endpackage

// ===== hdl/bfds_key_unit.sv =====
// ----------------------------------------------------------------------------
// bfds_key_unit: squared distance key pipeline
// Picks the object center, then computes the exact squared distance to the
// camera point in three stages: differences, squares, sum.
// ----------------------------------------------------------------------------
module bfds_key_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_store,
	input  logic                                   in_last,
	input  logic [bfds_pkg::TAG_W-1:0]             tag,
	input  logic                                   pos_valid,
	input  logic signed [bfds_pkg::COORD_W-1:0]    pos_x,
	input  logic signed [bfds_pkg::COORD_W-1:0]    pos_y,
	input  logic signed [bfds_pkg::COORD_W-1:0]    pos_z,
	input  logic                                   trans_valid,
	input  logic signed [bfds_pkg::COORD_W-1:0]    trans_x,
	input  logic signed [bfds_pkg::COORD_W-1:0]    trans_y,
	input  logic signed [bfds_pkg::COORD_W-1:0]    trans_z,
	input  logic signed [bfds_pkg::COORD_W-1:0]    camera_x,
	input  logic signed [bfds_pkg::COORD_W-1:0]    camera_y,
	input  logic signed [bfds_pkg::COORD_W-1:0]    camera_z,
	output bfds_pkg::key_word_t                    out_word
);

	logic signed [bfds_pkg::COORD_W-1:0]   cx, cy, cz;
	logic signed [bfds_pkg::DIFF_W-1:0]    dx_s1, dy_s1, dz_s1;
	logic signed [2*bfds_pkg::DIFF_W-1:0]  px, py, pz;
	logic [bfds_pkg::SQ_W-1:0]             sqx_s2, sqy_s2, sqz_s2;
	logic [bfds_pkg::KEY_W-1:0]            key_s3;
	logic [bfds_pkg::TAG_W-1:0]            tag_s1, tag_s2, tag_s3;
	logic                                  store_s1, store_s2, store_s3;
	logic                                  last_s1, last_s2, last_s3;

	function automatic logic signed [bfds_pkg::DIFF_W-1:0] DIFF_SEXT(
		input logic signed [bfds_pkg::COORD_W-1:0] v
	);
		return {v[bfds_pkg::COORD_W-1], v};
	endfunction

	// center: position, else translation, else origin
	always_comb begin
		priority if (pos_valid) begin
			cx = pos_x;
			cy = pos_y;
			cz = pos_z;
		end else if (trans_valid) begin
			cx = trans_x;
			cy = trans_y;
			cz = trans_z;
		end else begin
			cx = '0;
			cy = '0;
			cz = '0;
		end
	end

	assign px = dx_s1 * dx_s1;
	assign py = dy_s1 * dy_s1;
	assign pz = dz_s1 * dz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_s1 <= 1'b0;
			store_s2 <= 1'b0;
			store_s3 <= 1'b0;
			last_s1  <= 1'b0;
			last_s2  <= 1'b0;
			last_s3  <= 1'b0;
		end else begin
			store_s1 <= in_store;
			store_s2 <= store_s1;
			store_s3 <= store_s2;
			last_s1  <= in_last;
			last_s2  <= last_s1;
			last_s3  <= last_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1  <= DIFF_SEXT(cx) - DIFF_SEXT(camera_x);
		dy_s1  <= DIFF_SEXT(cy) - DIFF_SEXT(camera_y);
		dz_s1  <= DIFF_SEXT(cz) - DIFF_SEXT(camera_z);
		tag_s1 <= tag;
		// squares are non-negative and below 2^48
		sqx_s2 <= px[bfds_pkg::SQ_W-1:0];
		sqy_s2 <= py[bfds_pkg::SQ_W-1:0];
		sqz_s2 <= pz[bfds_pkg::SQ_W-1:0];
		tag_s2 <= tag_s1;
		key_s3 <= bfds_pkg::KEY_W'(sqx_s2) + bfds_pkg::KEY_W'(sqy_s2)
			+ bfds_pkg::KEY_W'(sqz_s2);
		tag_s3 <= tag_s2;
	end

	assign out_word.store = store_s3;
	assign out_word.last  = last_s3;
	assign out_word.key   = key_s3;
	assign out_word.tag   = tag_s3;

endmodule

// ===== hdl/bfds_cell.sv =====
// ----------------------------------------------------------------------------
// bfds_cell: one slot of the insertion chain
// Holds one entry; the chain stays sorted farthest first. On insert a cell
// takes the new entry, its lower neighbor's or its own; on drain it takes the upper.
// ----------------------------------------------------------------------------
module bfds_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bfds_pkg::cell_ctrl_t          ctrl,
	input  logic [bfds_pkg::KEY_W-1:0]    new_key,
	input  logic [bfds_pkg::TAG_W-1:0]    new_tag,
	input  bfds_pkg::entry_t              lower,
	input  logic                          lower_ins,
	input  bfds_pkg::entry_t              upper,
	output logic                          ins,
	output bfds_pkg::entry_t              ent
);

	logic valid_q;
	logic [bfds_pkg::KEY_W-1:0] key_q;
	logic [bfds_pkg::TAG_W-1:0] tag_q;

	// strict compare keeps equal keys in arrival order
	assign ins = !valid_q || (new_key > key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.insert) begin
			if (lower_ins) begin
				valid_q <= lower.valid;
			end else if (ins) begin
				valid_q <= 1'b1;
			end
		end else if (ctrl.shift_down) begin
			valid_q <= upper.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (lower_ins) begin
				key_q <= lower.key;
				tag_q <= lower.tag;
			end else if (ins) begin
				key_q <= new_key;
				tag_q <= new_tag;
			end
		end else if (ctrl.shift_down) begin
			key_q <= upper.key;
			tag_q <= upper.tag;
		end
	end

	assign ent.valid = valid_q;
	assign ent.key   = key_q;
	assign ent.tag   = tag_q;

endmodule

// ===== hdl/back_to_front_depth_sorter.sv =====
// ----------------------------------------------------------------------------
// back_to_front_depth_sorter: painter's order by squared camera distance
// Collects a batch of objects into a sorted chain of cells and emits their
// tags farthest first once the batch's last object has been keyed.
// ----------------------------------------------------------------------------
// load: one word per cycle while in ST_LOAD; each object is keyed in the key
// unit's difference, square and sum registers, then inserted into the cell
// chain through a broadcast compare in every cell; the first result follows
// the last word's insertion, then one result per cycle while m_tready is high
// no input is taken from the last word of a batch until its final result
// reset clears the camera registers, the cell valid bits, the count and flag
module back_to_front_depth_sorter #(
	parameter int MAX_OBJECTS = bfds_pkg::MAX_OBJECTS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [bfds_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [bfds_pkg::COORD_W-1:0]      cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// object_tag, pos_x, pos_y, pos_z, trans_x, trans_y, trans_z
	input  logic [bfds_pkg::S_TDATA_W-1:0]    s_tdata,
	// pos_valid, trans_valid
	input  logic [bfds_pkg::S_TUSER_W-1:0]    s_tuser,
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// sorted_tag
	output logic [bfds_pkg::M_TDATA_W-1:0]    m_tdata,
	// overflow
	output logic [bfds_pkg::M_TUSER_W-1:0]    m_tuser,
	output logic                              m_tlast
);

	localparam int CNT_W = $clog2(MAX_OBJECTS + 1);
	localparam int CW    = bfds_pkg::COORD_W;
	localparam int TW    = bfds_pkg::TAG_W;

	bfds_pkg::state_t     state_q, state_d;
	bfds_pkg::key_word_t  kw;
	bfds_pkg::cell_ctrl_t ctrl;

	logic signed [CW-1:0] camera_x_q, camera_y_q, camera_z_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 dropped_q;
	logic                 in_acc, out_acc, full, in_store, drain_done;

	bfds_pkg::entry_t     ent   [MAX_OBJECTS];
	bfds_pkg::entry_t     lower [MAX_OBJECTS];
	bfds_pkg::entry_t     upper [MAX_OBJECTS];
	logic                 ins   [MAX_OBJECTS];
	logic                 lins  [MAX_OBJECTS];
	logic [MAX_OBJECTS-1:0] valid_vec;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			camera_x_q <= '0;
			camera_y_q <= '0;
			camera_z_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				bfds_pkg::REG_CAMERA_X: camera_x_q <= cfg_wdata;
				bfds_pkg::REG_CAMERA_Y: camera_y_q <= cfg_wdata;
				bfds_pkg::REG_CAMERA_Z: camera_z_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign in_acc     = s_tvalid && s_tready;
	assign out_acc    = m_tvalid && m_tready;
	assign full       = (cnt_q == CNT_W'(MAX_OBJECTS));
	assign in_store   = in_acc && !full;
	assign drain_done = out_acc && m_tlast;

	// fill count and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			dropped_q <= 1'b0;
		end else begin
			if (in_acc) begin
				if (s_tlast) begin
					cnt_q <= '0;
				end else if (!full) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (in_acc && full) begin
				dropped_q <= 1'b1;
			end else if (drain_done) begin
				dropped_q <= 1'b0;
			end
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfds_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bfds_pkg::ST_LOAD:  if (in_acc && s_tlast) state_d = bfds_pkg::ST_FLUSH;
			bfds_pkg::ST_FLUSH: if (kw.last) state_d = bfds_pkg::ST_DRAIN;
			bfds_pkg::ST_DRAIN: if (drain_done) state_d = bfds_pkg::ST_LOAD;
			default:            state_d = bfds_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		s_tready = (state_q == bfds_pkg::ST_LOAD);
		m_tvalid = (state_q == bfds_pkg::ST_DRAIN) && ent[0].valid;
	end

	bfds_key_unit u_key (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_store    (in_store),
		.in_last     (in_acc && s_tlast),
		.tag         (s_tdata[TW-1:0]),
		.pos_valid   (s_tuser[0]),
		.pos_x       (s_tdata[TW+CW-1:TW]),
		.pos_y       (s_tdata[TW+2*CW-1:TW+CW]),
		.pos_z       (s_tdata[TW+3*CW-1:TW+2*CW]),
		.trans_valid (s_tuser[1]),
		.trans_x     (s_tdata[TW+4*CW-1:TW+3*CW]),
		.trans_y     (s_tdata[TW+5*CW-1:TW+4*CW]),
		.trans_z     (s_tdata[TW+6*CW-1:TW+5*CW]),
		.camera_x    (camera_x_q),
		.camera_y    (camera_y_q),
		.camera_z    (camera_z_q),
		.out_word    (kw)
	);

	assign ctrl.insert     = kw.store;
	assign ctrl.shift_down = out_acc;

	// cell chain, cell 0 holds the farthest entry
	for (genvar i = 0; i < MAX_OBJECTS; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign lower[i] = '0;
			assign lins[i]  = 1'b0;
		end else begin : g_mid
			assign lower[i] = ent[i-1];
			assign lins[i]  = ins[i-1];
		end
		if (i == MAX_OBJECTS - 1) begin : g_end
			assign upper[i] = '0;
		end else begin : g_up
			assign upper[i] = ent[i+1];
		end

		bfds_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.new_key   (kw.key),
			.new_tag   (kw.tag),
			.lower     (lower[i]),
			.lower_ins (lins[i]),
			.upper     (upper[i]),
			.ins       (ins[i]),
			.ent       (ent[i])
		);

		assign valid_vec[i] = ent[i].valid;
	end

	assign m_tdata = ent[0].tag;
	assign m_tlast = !ent[1].valid;
	assign m_tuser = dropped_q;

	// no input is taken while results are pending
	a_no_load_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input accepted while draining");

	// occupied cells stay packed from cell 0 upward
	a_cells_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec + MAX_OBJECTS'(1)) & valid_vec) == '0)
		else $error("cell chain has a gap");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_OBJECTS))
		else $error("fill count above capacity");

	// the chain is empty after the final word of a run
	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		drain_done |=> (valid_vec == '0) && !m_tvalid)
		else $error("entries left after final word");

	a_drop_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && full) |=> dropped_q)
		else $error("dropped object not flagged");

endmodule
